FILE: design/dld_pkg.sv
//------------------------------------------------------------------------------
// dld_pkg: shared types and constants for the descent and landing detector
// Phase codes, item kinds, register indexes, reset values and state structs.
//------------------------------------------------------------------------------
`default_nettype none

package dld_pkg;

   localparam int unsigned SPEED_W = 16;
   localparam int unsigned DWELL_W = 16;
   localparam int unsigned TICK_W  = 24;
   localparam int unsigned CSR_W   = 24;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};
   localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};

   // reset values of the configuration registers
   localparam logic signed [SPEED_W-1:0] RST_FALL_THRESHOLD = -16'sd100;
   localparam logic [DWELL_W-1:0]        RST_FALL_DWELL     = 16'd10;
   localparam logic [DWELL_W-1:0]        RST_LAND_DWELL     = 16'd50;
   localparam logic [TICK_W-1:0]         RST_TIMEOUT        = 24'd60000;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_WAIT_FALL = 3'd1,
      PH_WAIT_LAND = 3'd2,
      PH_DONE      = 3'd3,
      PH_TIMEOUT   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_STOP  = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FALL_THRESHOLD = 2'd0,
      CSR_FALL_DWELL     = 2'd1,
      CSR_LAND_DWELL     = 2'd2,
      CSR_TIMEOUT        = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] fall_threshold;
      logic [DWELL_W-1:0]        fall_dwell;
      logic [DWELL_W-1:0]        land_dwell;
      logic [TICK_W-1:0]         timeout;
   } dld_cfg_type;

   typedef struct packed {
      phase_type           phase;
      logic [DWELL_W-1:0]  dwell;
      logic [TICK_W-1:0]   ticks;
   } dld_state_type;

endpackage : dld_pkg

`default_nettype wire

FILE: design/dld_step.sv
//------------------------------------------------------------------------------
// dld_step: next-state logic of the phase sequencer
// Computes the state after one item and the detection flags for its result.
//------------------------------------------------------------------------------
`default_nettype none

module dld_step (
   input  wire dld_pkg::dld_state_type state_cur,
   input  wire dld_pkg::dld_cfg_type   cfg,
   input  wire logic [1:0]        func,
   input  wire logic signed [dld_pkg::SPEED_W-1:0] vertical_speed,
   output dld_pkg::dld_state_type state_nxt,
   output logic                   fall_flag,
   output logic                   land_flag
);
   import dld_pkg::*;

   logic                falling;
   logic [TICK_W-1:0]   ticks_inc;
   logic                timed_out;
   logic [DWELL_W-1:0]  dwell_inc;
   logic [DWELL_W-1:0]  dwell_fall;
   logic [DWELL_W-1:0]  dwell_land;
   logic                fall_hit;
   logic                land_hit;
   logic                active_tick;

   assign falling     = vertical_speed <= cfg.fall_threshold;
   assign ticks_inc   = (state_cur.ticks == TICK_MAX) ? state_cur.ticks
                                                      : state_cur.ticks + 1'b1;
   assign timed_out   = ticks_inc >= cfg.timeout;
   assign dwell_inc   = (state_cur.dwell == DWELL_MAX) ? state_cur.dwell
                                                       : state_cur.dwell + 1'b1;
   assign dwell_fall  = falling ? dwell_inc : '0;
   assign dwell_land  = falling ? '0 : dwell_inc;
   assign fall_hit    = dwell_fall > cfg.fall_dwell;
   assign land_hit    = dwell_land > cfg.land_dwell;
   assign active_tick = (func == FUNC_TICK) &&
                        ((state_cur.phase == PH_WAIT_FALL) ||
                         (state_cur.phase == PH_WAIT_LAND));

   // next phase
   always_comb begin
      state_nxt.phase = state_cur.phase;
      unique case (func)
         FUNC_START: begin
            if (state_cur.phase == PH_IDLE) begin
               state_nxt.phase = PH_WAIT_FALL;
            end
         end
         FUNC_STOP: begin
            state_nxt.phase = PH_IDLE;
         end
         FUNC_TICK: begin
            if (active_tick) begin
               if (timed_out) begin
                  state_nxt.phase = PH_TIMEOUT;
               end else if (state_cur.phase == PH_WAIT_FALL) begin
                  if (fall_hit) begin
                     state_nxt.phase = PH_WAIT_LAND;
                  end
               end else if (land_hit) begin
                  state_nxt.phase = PH_DONE;
               end
            end
         end
         default: begin
            state_nxt.phase = state_cur.phase;
         end
      endcase
   end

   // counters and flags
   always_comb begin
      state_nxt.dwell = state_cur.dwell;
      state_nxt.ticks = state_cur.ticks;
      fall_flag       = 1'b0;
      land_flag       = 1'b0;
      unique case (func)
         FUNC_START: begin
            if (state_cur.phase == PH_IDLE) begin
               state_nxt.dwell = '0;
               state_nxt.ticks = '0;
            end
         end
         FUNC_STOP: begin
            state_nxt.dwell = '0;
            state_nxt.ticks = '0;
         end
         FUNC_TICK: begin
            if (active_tick) begin
               state_nxt.ticks = ticks_inc;
               if (!timed_out) begin
                  if (state_cur.phase == PH_WAIT_FALL) begin
                     state_nxt.dwell = fall_hit ? '0 : dwell_fall;
                     fall_flag       = fall_hit;
                  end else begin
                     state_nxt.dwell = dwell_land;
                     land_flag       = land_hit;
                  end
               end
            end
         end
         default: begin
            state_nxt.dwell = state_cur.dwell;
         end
      endcase
   end

endmodule : dld_step

`default_nettype wire

FILE: design/descent_and_landing_detector_unit.sv
//------------------------------------------------------------------------------
// descent_and_landing_detector_unit: flight phase sequencer
// Arms on start, detects a sustained descent and then a sustained stop of
// descent from vertical speed samples, with an overall tick timeout.
//------------------------------------------------------------------------------
// channel   ports                                   direction
// req       req_valid/req_ready, req_func,          in   one item per sample,
//           req_vertical_speed                           start or stop
// rsp       rsp_valid/rsp_ready, rsp_phase,         out  one item per req item
//           rsp_fall_detected, rsp_land_detected
// csr       csr_we, csr_index, csr_wdata            in   register writes
//
// An item is captured in the input register, evaluated combinationally and lands
// in the result register; one item per cycle sustained while rsp is not stalled.
// Phase state advances when the item moves into the result stage.
// A stalled rsp holds the result register and the input register fills; req
// keeps accepting as long as the input register can drain.
// Reset: synchronous, returns the phase to idle, counters to zero and the
// registers to their defaults.
//------------------------------------------------------------------------------
`default_nettype none

module descent_and_landing_detector_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item input
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_func,
   input  wire logic signed [dld_pkg::SPEED_W-1:0] req_vertical_speed,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_phase,
   output logic                                   rsp_fall_detected,
   output logic                                   rsp_land_detected,
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [dld_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dld_pkg::CSR_W-1:0]         csr_wdata
);
   import dld_pkg::*;

   dld_cfg_type   cfg_ff;
   dld_state_type state_ff;
   dld_state_type state_in;

   // input register
   logic                      in_valid_ff;
   logic [1:0]                in_func_ff;
   logic signed [SPEED_W-1:0] in_speed_ff;

   // result register
   logic       out_valid_ff;
   phase_type  out_phase_ff;
   logic       out_fall_ff;
   logic       out_land_ff;

   logic       fall_in;
   logic       land_in;
   logic       advance;

   // the input item moves on when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dld_step u_step (
      .state_cur      (state_ff),
      .cfg            (cfg_ff),
      .func           (in_func_ff),
      .vertical_speed (in_speed_ff),
      .state_nxt      (state_in),
      .fall_flag      (fall_in),
      .land_flag      (land_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fall_threshold <= RST_FALL_THRESHOLD;
         cfg_ff.fall_dwell     <= RST_FALL_DWELL;
         cfg_ff.land_dwell     <= RST_LAND_DWELL;
         cfg_ff.timeout        <= RST_TIMEOUT;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FALL_THRESHOLD: cfg_ff.fall_threshold <= csr_wdata[SPEED_W-1:0];
            CSR_FALL_DWELL:     cfg_ff.fall_dwell     <= csr_wdata[DWELL_W-1:0];
            CSR_LAND_DWELL:     cfg_ff.land_dwell     <= csr_wdata[DWELL_W-1:0];
            CSR_TIMEOUT:        cfg_ff.timeout        <= csr_wdata[TICK_W-1:0];
            default:            cfg_ff.timeout        <= cfg_ff.timeout;
         endcase
      end
   end

   // sequencer state, committed as the item is evaluated
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_IDLE;
         state_ff.dwell <= '0;
         state_ff.ticks <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff  <= req_func;
         in_speed_ff <= req_vertical_speed;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_phase_ff <= state_in.phase;
         out_fall_ff  <= fall_in;
         out_land_ff  <= land_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_phase         = 3'(out_phase_ff);
   assign rsp_fall_detected = out_fall_ff;
   assign rsp_land_detected = out_land_ff;

endmodule : descent_and_landing_detector_unit

`default_nettype wire

FILE: tb/sv/dld_flight_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// dld_flight_checker: predictor and result checker for the descent detector
// Mirrors the register writes, runs its own flight phase sequencer for each
// accepted request item and compares every accepted result item against the
// oldest predicted one. Mismatch and bookkeeping counts go back to the top.
//------------------------------------------------------------------------------

module dld_flight_checker
   import dld_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic signed [SPEED_W-1:0]  req_vertical_speed,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [2:0]                 rsp_phase,
   input  logic                       rsp_fall_detected,
   input  logic                       rsp_land_detected,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding,
   output int                         checked_count,
   output int                         descent_count,
   output int                         landing_count,
   output int                         timeout_count
);

   typedef struct packed {
      phase_type phase;
      logic      fall;
      logic      land;
   } flight_result_type;

   flight_result_type expected_q[$];

   // register mirror
   logic signed [SPEED_W-1:0] fall_threshold;
   logic [DWELL_W-1:0]        fall_dwell;
   logic [DWELL_W-1:0]        land_dwell;
   logic [TICK_W-1:0]         timeout_limit;

   // sequencer mirror
   phase_type                 flight_phase;
   logic [DWELL_W-1:0]        dwell_run;
   logic [TICK_W-1:0]         ticks_run;

   int mismatches, checked, descents, landings, timeouts;

   always @(posedge clock) begin : predict_and_compare
      flight_result_type next_r, want_r;
      logic              falling;
      if (reset) begin
         fall_threshold = RST_FALL_THRESHOLD;
         fall_dwell     = RST_FALL_DWELL;
         land_dwell     = RST_LAND_DWELL;
         timeout_limit  = RST_TIMEOUT;
         flight_phase   = PH_IDLE;
         dwell_run      = '0;
         ticks_run      = '0;
         expected_q.delete();
         mismatches = 0;
         checked    = 0;
         descents   = 0;
         landings   = 0;
         timeouts   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FALL_THRESHOLD: fall_threshold = csr_wdata[SPEED_W-1:0];
               CSR_FALL_DWELL:     fall_dwell     = csr_wdata[DWELL_W-1:0];
               CSR_LAND_DWELL:     land_dwell     = csr_wdata[DWELL_W-1:0];
               CSR_TIMEOUT:        timeout_limit  = csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            next_r.fall = 1'b0;
            next_r.land = 1'b0;
            falling = (req_vertical_speed <= fall_threshold);
            case (req_func)
               FUNC_START: begin
                  if (flight_phase == PH_IDLE) begin
                     flight_phase = PH_WAIT_FALL;
                     dwell_run    = '0;
                     ticks_run    = '0;
                  end
               end
               FUNC_STOP: begin
                  flight_phase = PH_IDLE;
                  dwell_run    = '0;
                  ticks_run    = '0;
               end
               FUNC_TICK: begin
                  if (flight_phase == PH_WAIT_FALL || flight_phase == PH_WAIT_LAND) begin
                     if (ticks_run != TICK_MAX)
                        ticks_run = ticks_run + 1'b1;
                     if (ticks_run >= timeout_limit) begin
                        // timeout beats any detection on the same tick
                        flight_phase = PH_TIMEOUT;
                        timeouts++;
                     end else if (flight_phase == PH_WAIT_FALL) begin
                        if (!falling)
                           dwell_run = '0;
                        else if (dwell_run != DWELL_MAX)
                           dwell_run = dwell_run + 1'b1;
                        if (dwell_run > fall_dwell) begin
                           flight_phase = PH_WAIT_LAND;
                           dwell_run    = '0;
                           next_r.fall  = 1'b1;
                           descents++;
                        end
                     end else begin
                        if (falling)
                           dwell_run = '0;
                        else if (dwell_run != DWELL_MAX)
                           dwell_run = dwell_run + 1'b1;
                        if (dwell_run > land_dwell) begin
                           flight_phase = PH_DONE;
                           next_r.land  = 1'b1;
                           landings++;
                        end
                     end
                  end
               end
               default: ;
            endcase
            next_r.phase = flight_phase;
            expected_q.push_back(next_r);
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result item phase %0d fall %b land %b",
                           $realtime, rsp_phase, rsp_fall_detected, rsp_land_detected);
            end else begin
               want_r = expected_q.pop_front();
               checked++;
               if (rsp_phase !== want_r.phase || rsp_fall_detected !== want_r.fall ||
                   rsp_land_detected !== want_r.land) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result %0d: phase exp %0d got %0d, fall exp %b got %b, land exp %b got %b",
                              $realtime, checked, want_r.phase, rsp_phase, want_r.fall,
                              rsp_fall_detected, want_r.land, rsp_land_detected);
               end
            end
         end
      end
      mismatch_count <= mismatches;
      outstanding    <= expected_q.size();
      checked_count  <= checked;
      descent_count  <= descents;
      landing_count  <= landings;
      timeout_count  <= timeouts;
   end

endmodule : dld_flight_checker

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top: stimulus and verdict for the descent and landing detector
// Drives start, stop and speed sample items through the request channel under
// a series of register settings, with random stalls on both channels. A
// checker beside the block predicts and compares every result item.
//------------------------------------------------------------------------------

module tb_top;
   import dld_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_func;
   logic signed [SPEED_W-1:0] req_vertical_speed;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [2:0]                rsp_phase;
   logic                      rsp_fall_detected;
   logic                      rsp_land_detected;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_W-1:0]          csr_wdata;

   int mismatch_count, outstanding, checked_count;
   int descent_count, landing_count, timeout_count;

   // idle percentages of sender and receiver, changed per epoch
   int send_idle_pct = 36;
   int take_idle_pct = 63;
   int items_sent    = 0;

   // current register values, kept so the sequences can be shaped to them
   logic signed [SPEED_W-1:0] thr_now = RST_FALL_THRESHOLD;
   logic [DWELL_W-1:0]        fall_dwell_now = RST_FALL_DWELL;
   logic [DWELL_W-1:0]        land_dwell_now = RST_LAND_DWELL;

   descent_and_landing_detector_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_vertical_speed (req_vertical_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_phase          (rsp_phase),
      .rsp_fall_detected  (rsp_fall_detected),
      .rsp_land_detected  (rsp_land_detected),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   dld_flight_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_vertical_speed (req_vertical_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_phase          (rsp_phase),
      .rsp_fall_detected  (rsp_fall_detected),
      .rsp_land_detected  (rsp_land_detected),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding),
      .checked_count      (checked_count),
      .descent_count      (descent_count),
      .landing_count      (landing_count),
      .timeout_count      (timeout_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: reports failure and ends the run if it is still going.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: ready re-rolled every falling edge from the current idle rate.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // One item through the request channel. Starts at a falling edge, may idle
   // first, then holds valid and payload until the accepting rising edge.
   task automatic send_item(func_type kind, logic signed [SPEED_W-1:0] speed);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= kind;
      req_vertical_speed <= speed;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted result item has come back.
   task automatic wait_for_results();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Only called with the block drained.
   task automatic apply_settings(logic signed [SPEED_W-1:0] thr, logic [DWELL_W-1:0] fdw,
                                 logic [DWELL_W-1:0] ldw, logic [TICK_W-1:0] tmo);
      write_reg(CSR_FALL_THRESHOLD, {{(CSR_W-SPEED_W){1'b0}}, thr});
      write_reg(CSR_FALL_DWELL, {{(CSR_W-DWELL_W){1'b0}}, fdw});
      write_reg(CSR_LAND_DWELL, {{(CSR_W-DWELL_W){1'b0}}, ldw});
      write_reg(CSR_TIMEOUT, tmo);
      @(negedge clock);
      csr_we         <= 1'b0;
      thr_now        = thr;
      fall_dwell_now = fdw;
      land_dwell_now = ldw;
   endtask

   // A speed on the requested side of the threshold; a quarter of the time
   // exactly at the boundary. If that side is empty, any speed.
   function automatic logic signed [SPEED_W-1:0] pick_speed(bit want_fall);
      int lo, hi;
      lo = want_fall ? -32768 : int'(thr_now) + 1;
      hi = want_fall ? int'(thr_now) : 32767;
      if (lo > hi)
         return SPEED_W'($urandom);
      if ($urandom_range(0, 3) == 0)
         return SPEED_W'(want_fall ? hi : lo);
      return SPEED_W'(lo + $urandom_range(0, hi - lo));
   endfunction

   // Well-formed flight: (stop), start, a falling run around the fall dwell
   // (random length up to 40 if the dwell is 40 or more), a calm run likewise
   // around the land dwell, with rare blips that reset the count, then a few trailing ticks or starts.
   task automatic fly_sequence();
      int fall_len, land_len;
      if ($urandom_range(0, 3) != 0)
         send_item(FUNC_STOP, SPEED_W'($urandom));
      send_item(FUNC_START, SPEED_W'($urandom));
      fall_len = (fall_dwell_now < 40) ? fall_dwell_now + $urandom_range(0, 3)
                                       : $urandom_range(1, 40);
      land_len = (land_dwell_now < 40) ? land_dwell_now + $urandom_range(0, 3)
                                       : $urandom_range(1, 40);
      repeat (fall_len)
         send_item(FUNC_TICK, pick_speed($urandom_range(0, 19) != 0));
      repeat (land_len)
         send_item(FUNC_TICK, pick_speed($urandom_range(0, 19) == 0));
      repeat ($urandom_range(0, 3))
         send_item(($urandom_range(0, 3) == 0) ? FUNC_START : FUNC_TICK,
                   SPEED_W'($urandom));
   endtask

   // Mostly well-formed flights, the rest random items of any kind.
   task automatic run_random(int quota);
      int first;
      first = items_sent;
      while (items_sent - first < quota) begin
         if ($urandom_range(0, 99) < 80)
            fly_sequence();
         else
            repeat ($urandom_range(1, 6))
               send_item(func_type'($urandom_range(0, 2)), SPEED_W'($urandom));
      end
      wait_for_results();
   endtask

   initial begin
      req_valid          = 1'b0;
      req_func           = FUNC_TICK;
      req_vertical_speed = '0;
      csr_we             = 1'b0;
      csr_index          = CSR_FALL_THRESHOLD;
      csr_wdata          = '0;
      reset              = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      //--- directed: reset register values, threshold boundary at -100
      send_item(FUNC_TICK, -16'sd32768);  // tick in idle: nothing
      send_item(FUNC_STOP, 16'sd0);       // stop in idle
      send_item(FUNC_START, 16'sd0);
      send_item(FUNC_START, 16'sd0);      // start while armed: ignored
      send_item(FUNC_TICK, -16'sd100);    // at threshold counts as falling
      send_item(FUNC_TICK, -16'sd99);     // just above clears the count
      send_item(FUNC_STOP, 16'sd0);
      wait_for_results();

      //--- directed: short dwells, full descent and landing
      apply_settings(16'sd0, 16'd1, 16'd2, TICK_MAX);
      send_item(FUNC_START, 16'sd0);
      send_item(FUNC_TICK, 16'sd0);
      send_item(FUNC_TICK, -16'sd32768);  // second falling tick: descent
      send_item(FUNC_TICK, 16'sd1);
      send_item(FUNC_TICK, -16'sd1);      // falling blip clears the calm count
      repeat (3) send_item(FUNC_TICK, 16'sd32767);  // third calm tick: landing
      send_item(FUNC_TICK, -16'sd32768);  // tick after completion: nothing
      send_item(FUNC_START, 16'sd0);      // start in complete: ignored
      send_item(FUNC_STOP, 16'sd0);
      wait_for_results();

      //--- directed: timeout on the same tick as descent; timeout wins
      apply_settings(16'sd0, 16'd1, 16'd2, 24'd2);
      send_item(FUNC_START, 16'sd0);
      send_item(FUNC_TICK, -16'sd5);
      send_item(FUNC_TICK, -16'sd5);
      send_item(FUNC_TICK, 16'sd5);       // timed out is terminal
      send_item(FUNC_START, 16'sd0);      // start in timed out: ignored
      send_item(FUNC_STOP, 16'sd0);
      wait_for_results();

      //--- random, epoch 1: sender idles 36%, receiver 63%
      apply_settings(RST_FALL_THRESHOLD, RST_FALL_DWELL, RST_LAND_DWELL, RST_TIMEOUT);
      run_random(240);
      apply_settings(-16'sd32768, 16'd0, 16'd0, 24'd24);
      run_random(240);
      apply_settings(16'sd32767, 16'd0, DWELL_MAX, TICK_MAX);
      run_random(240);

      //--- random, epoch 2: swapped rates
      send_idle_pct = 63;
      take_idle_pct = 36;
      apply_settings(SPEED_W'($urandom), DWELL_W'($urandom_range(0, 15)),
                     DWELL_W'($urandom_range(0, 15)), 24'd0);
      run_random(240);
      apply_settings(SPEED_W'($urandom), DWELL_W'($urandom_range(0, 20)),
                     DWELL_W'($urandom_range(0, 20)), TICK_W'($urandom_range(10, 300)));
      run_random(240);
      apply_settings(16'sd0, 16'd3, 16'd6, TICK_W'($urandom_range(40, 120)));
      run_random(240);

      //--- random, epoch 3: no idling
      send_idle_pct = 0;
      take_idle_pct = 0;
      apply_settings(SPEED_W'($urandom), DWELL_W'($urandom), DWELL_W'($urandom),
                     TICK_W'($urandom));
      run_random(240);
      apply_settings(pick_speed($urandom_range(0, 1) != 0), DWELL_W'($urandom_range(0, 8)),
                     DWELL_W'($urandom_range(0, 8)), TICK_W'($urandom_range(5, 200)));
      run_random(270);

      // pipeline is two deep; leave room for any stray result
      repeat (20) @(posedge clock);

      $display("Sent %0d items over eleven register settings, stalls on both channels.",
               items_sent);
      $display("Checked %0d results: %0d descents, %0d landings, %0d timeouts predicted.",
               checked_count, descent_count, landing_count, timeout_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : tb_top
